/* rtl/core/bcp_pkg.sv */
// Shared types, constants and curve functions for the battery charge block.
package bcp_pkg;

	// Register map: index of each configuration register
	localparam logic REG_EMPTY_MV = 1'b0;

	localparam logic [15:0] EMPTY_MV_RST = 16'd1000;
	localparam logic [6:0]  PCT_FULL     = 7'd100;

	// Alkaline discharge curve, 100 % down to 0 % in steps of 10 %
	localparam logic [15:0] CURVE_MV [11] = '{
		16'd1600, 16'd1400, 16'd1320, 16'd1280, 16'd1240, 16'd1210,
		16'd1180, 16'd1160, 16'd1100, 16'd1030, 16'd900
	};

	// Millivolts per percent inside segment k (span of the segment over ten)
	localparam logic [4:0] SEG_STEP [11] = '{
		5'd0, 5'd20, 5'd8, 5'd4, 5'd4, 5'd3, 5'd3, 5'd2, 5'd6, 5'd7, 5'd13
	};

	// Position of a voltage on the curve; segment 0 means saturated
	typedef struct packed {
		logic [3:0] seg;
		logic [6:0] base;
		logic [7:0] ofs;
	} curve_pos_t;

	// Partial quotient of the rescaling division
	typedef struct packed {
		logic [13:0] rem;
		logic [6:0]  quo;
	} div_t;

	// Find the segment, its lower percent and the offset above its lower point
	function automatic curve_pos_t curve_locate(logic [15:0] mv);
		curve_pos_t p;
		logic [3:0] k;
		k = 4'd1;
		for (int j = 1; j < 10; j++) begin
			if (mv < CURVE_MV[j]) begin
				k = k + 4'd1;
			end
		end
		if (mv >= CURVE_MV[0]) begin
			p.seg  = 4'd0;
			p.base = PCT_FULL;
			p.ofs  = 8'd0;
		end else if (mv <= CURVE_MV[10]) begin
			p.seg  = 4'd0;
			p.base = 7'd0;
			p.ofs  = 8'd0;
		end else begin
			p.seg  = k;
			p.base = PCT_FULL - 7'(k) * 7'd10;
			p.ofs  = 8'(mv - CURVE_MV[k]);
		end
		return p;
	endfunction

	// Whole percents within the segment: count the step thresholds passed
	function automatic logic [3:0] curve_frac(logic [3:0] seg, logic [7:0] ofs);
		logic [3:0] f;
		f = 4'd0;
		if (seg != 4'd0) begin
			for (int j = 1; j < 10; j++) begin
				if (ofs >= 8'(j) * {3'b000, SEG_STEP[seg]}) begin
					f = f + 4'd1;
				end
			end
		end
		return f;
	endfunction

	// Restoring division, n quotient bits from bit position top downward
	function automatic div_t div_steps(div_t d, logic [6:0] q, int top, int n);
		div_t r;
		logic [13:0] sub;
		r = d;
		for (int i = 0; i < n; i++) begin
			sub = {7'b0000000, q} << (top - i);
			if (r.rem >= sub) begin
				r.rem = r.rem - sub;
				r.quo[top - i] = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

/* rtl/core/battery_charge_percentage_top.sv */
// Battery charge percentage: curve lookup, rescale and pipelined divide.
//
// Usage: pulse start with battery_mv (millivolts) to hand in an item; busy
// stays low, so an item is taken on every cycle that start is high. At the
// end of the pipeline, done is high for one cycle with charge_percent
// (0 to 100). One result comes out per item, in order.
// Throughput is one item per cycle. The pipeline has an input register,
// segment search, interpolation, rescale setup and four divider stages:
// three of two quotient bits each and a last one of a single bit.
// The empty level is written through the APB port (register 0, byte
// address 0, low 16 bits) and is mapped through the curve by the minpos_q
// and min_q registers, so an item taken right after a write already sees
// the new level. Reset clears all valid bits, so no stray result appears,
// and sets the empty level to 1000 mV. The receiver cannot stall: each
// result is shown for exactly one cycle and must be taken then.
module battery_charge_percentage_top
	import bcp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] battery_mv,
	output logic        done,
	output logic [6:0]  charge_percent,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic        [15:0] empty_q;
	curve_pos_t         minpos_q;
	logic        [6:0]  min_q;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic        [15:0] mv_s1;
	curve_pos_t         pos_s2;
	logic        [6:0]  raw_s3;
	logic        [13:0] rem_s4;
	logic        [6:0]  q_s4, q_s5, q_s6, q_s7;
	div_t               dv_s5, dv_s6, dv_s7, dv_s8;

	logic               acc;
	logic               cfg_wr;
	div_t               dv_s4;

	assign busy   = 1'b0;
	assign acc    = start && !busy;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Hold the empty level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= EMPTY_MV_RST;
		end else if (cfg_wr && paddr[2] == REG_EMPTY_MV) begin
			empty_q <= pwdata[15:0];
		end
	end

	// Return the register on read; unmapped addresses read zero
	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_EMPTY_MV) begin
			prdata = {16'd0, empty_q};
		end
	end

	// Map the empty level through the curve in two steps
	always_ff @(posedge clk) begin
		minpos_q <= curve_locate(empty_q);
		min_q    <= minpos_q.base + 7'(curve_frac(minpos_q.seg, minpos_q.ofs));
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// Capture the item, locate it on the curve and interpolate
	always_ff @(posedge clk) begin
		mv_s1  <= battery_mv;
		pos_s2 <= curve_locate(mv_s1);
		raw_s3 <= pos_s2.base + 7'(curve_frac(pos_s2.seg, pos_s2.ofs));
	end

	// Set up the rescale: below empty gives 0, empty level at full gives 100
	always_ff @(posedge clk) begin
		if (raw_s3 < min_q) begin
			rem_s4 <= 14'd0;
			q_s4   <= 7'd1;
		end else if (min_q >= PCT_FULL) begin
			rem_s4 <= 14'(PCT_FULL);
			q_s4   <= 7'd1;
		end else begin
			rem_s4 <= 14'(raw_s3 - min_q) * 14'd100;
			q_s4   <= PCT_FULL - min_q;
		end
	end

	assign dv_s4.rem = rem_s4;
	assign dv_s4.quo = 7'd0;

	// Divide, two quotient bits per stage and one bit in the last stage
	always_ff @(posedge clk) begin
		dv_s5 <= div_steps(dv_s4, q_s4, 6, 2);
		q_s5  <= q_s4;
		dv_s6 <= div_steps(dv_s5, q_s5, 4, 2);
		q_s6  <= q_s5;
		dv_s7 <= div_steps(dv_s6, q_s6, 2, 2);
		q_s7  <= q_s6;
		dv_s8 <= div_steps(dv_s7, q_s7, 0, 1);
	end

	assign done           = v_s8;
	assign charge_percent = dv_s8.quo;

`ifndef SYNTHESIS
	// Every accepted item comes out as a done pulse at the end of the pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##8 done)
		else $error("result missing eight cycles after accept");

	// Results never exceed full charge
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> charge_percent <= PCT_FULL)
		else $error("charge_percent above 100");

	// Divider never sees a zero divisor
	a_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> q_s4 != 7'd0)
		else $error("zero divisor entered the divider");

	// Quotient fits in seven bits
	a_quo_fit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> rem_s4 < {q_s4, 7'b0000000})
		else $error("dividend too large for the divider");
`endif

endmodule
